/* rtl/vpt_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpt_pkg
// Types, codes and angle helpers shared by the valve positioner modules.
// ----------------------------------------------------------------------------
package vpt_pkg;

    localparam int ANGLE_W   = 9;
    localparam int HYST_W    = 6;
    localparam int TIMEOUT_W = 16;
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;

    localparam logic [ANGLE_W-1:0]   CLOSED_RST  = 9'd0;
    localparam logic [ANGLE_W-1:0]   TANK_RST    = 9'd90;
    localparam logic [ANGLE_W-1:0]   BARREL_RST  = 9'd180;
    localparam logic [HYST_W-1:0]    HYST_RST    = 6'd5;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = 16'd5000;

    typedef enum logic [1:0] {
        OP_TICK    = 2'd0,
        OP_MOVE    = 2'd1,
        OP_REFRESH = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        POS_CLOSED = 2'd0,
        POS_TANK   = 2'd1,
        POS_BARREL = 2'd2
    } pos_t;

    typedef enum logic [1:0] {
        DRV_BRAKE    = 2'd0,
        DRV_FORWARD  = 2'd1,
        DRV_BACKWARD = 2'd2
    } drive_t;

    typedef enum logic [2:0] {
        REG_CLOSED  = 3'd0,
        REG_TANK    = 3'd1,
        REG_BARREL  = 3'd2,
        REG_HYST    = 3'd3,
        REG_TIMEOUT = 3'd4
    } reg_idx_t;

    typedef struct packed {
        logic [ANGLE_W-1:0]   closed_angle;
        logic [ANGLE_W-1:0]   tank_angle;
        logic [ANGLE_W-1:0]   barrel_angle;
        logic [HYST_W-1:0]    hysteresis;
        logic [TIMEOUT_W-1:0] timeout_ticks;
    } cfg_t;

    typedef struct packed {
        pos_t low;
        pos_t mid;
        pos_t high;
    } rank_t;

    typedef struct packed {
        drive_t motor_drive;
        logic   busy_res;
        logic   finished;
        logic   succeeded;
        pos_t   position_class;
        pos_t   stored_position;
    } res_t;

    function automatic logic [ANGLE_W-1:0] pos_angle(cfg_t cfg, pos_t p);
        logic [ANGLE_W-1:0] a;
        if (p == POS_TANK) begin
            a = cfg.tank_angle;
        end else if (p == POS_BARREL) begin
            a = cfg.barrel_angle;
        end else begin
            a = cfg.closed_angle;
        end
        return a;
    endfunction

    // compares done one bit wider so that angle plus tolerance cannot wrap
    function automatic logic reached(logic [ANGLE_W-1:0] dest, logic [ANGLE_W-1:0] cur,
                                     logic [ANGLE_W-1:0] start, logic [HYST_W-1:0] hyst);
        logic [ANGLE_W:0] cur_w;
        logic [ANGLE_W:0] dest_w;
        logic [ANGLE_W:0] hyst_w;
        logic             r;
        cur_w  = {1'b0, cur};
        dest_w = {1'b0, dest};
        hyst_w = (ANGLE_W+1)'(hyst);
        priority if (start < dest) begin
            r = (cur_w + hyst_w) >= dest_w;
        end else if (start > dest) begin
            r = cur_w <= (dest_w + hyst_w);
        end else begin
            r = 1'b1;
        end
        return r;
    endfunction

    function automatic rank_t rank_angles(cfg_t cfg);
        logic [ANGLE_W-1:0] a;
        logic [ANGLE_W-1:0] b;
        rank_t              r;
        a      = cfg.barrel_angle;
        b      = cfg.barrel_angle;
        r.low  = POS_BARREL;
        r.high = POS_BARREL;
        if (cfg.closed_angle <= a) begin
            a     = cfg.closed_angle;
            r.low = POS_CLOSED;
        end
        if (cfg.closed_angle >= b) begin
            b      = cfg.closed_angle;
            r.high = POS_CLOSED;
        end
        if (cfg.tank_angle <= a) begin
            r.low = POS_TANK;
        end
        if (cfg.tank_angle >= b) begin
            r.high = POS_TANK;
        end
        priority if (r.high != POS_BARREL && r.low != POS_BARREL) begin
            r.mid = POS_BARREL;
        end else if (r.high != POS_CLOSED && r.low != POS_CLOSED) begin
            r.mid = POS_CLOSED;
        end else begin
            r.mid = POS_TANK;
        end
        return r;
    endfunction

    function automatic pos_t classify(cfg_t cfg, rank_t rk, logic [ANGLE_W-1:0] cur);
        logic [ANGLE_W:0] cur_w;
        logic [ANGLE_W:0] hyst_w;
        pos_t             p;
        cur_w  = {1'b0, cur};
        hyst_w = (ANGLE_W+1)'(cfg.hysteresis);
        priority if (cur_w <= ({1'b0, pos_angle(cfg, rk.low)} + hyst_w)) begin
            p = rk.low;
        end else if ((cur_w + hyst_w) >= {1'b0, pos_angle(cfg, rk.high)}) begin
            p = rk.high;
        end else begin
            p = rk.mid;
        end
        return p;
    endfunction

endpackage

/* rtl/vpt_cfg_regs.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpt_cfg_regs
// APB register file holding the position angles, tolerance and timeout.
// ----------------------------------------------------------------------------
module vpt_cfg_regs
    import vpt_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output cfg_t                  cfg
);

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    logic     wr_en;
    reg_idx_t idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign idx    = reg_idx_t'(paddr[APB_ADDR_W-1:2]);
    assign cfg    = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (idx)
                REG_CLOSED:  cfg_next.closed_angle  = pwdata[ANGLE_W-1:0];
                REG_TANK:    cfg_next.tank_angle    = pwdata[ANGLE_W-1:0];
                REG_BARREL:  cfg_next.barrel_angle  = pwdata[ANGLE_W-1:0];
                REG_HYST:    cfg_next.hysteresis    = pwdata[HYST_W-1:0];
                REG_TIMEOUT: cfg_next.timeout_ticks = pwdata[TIMEOUT_W-1:0];
                default:     cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_CLOSED:  prdata = APB_DATA_W'(cfg_reg.closed_angle);
            REG_TANK:    prdata = APB_DATA_W'(cfg_reg.tank_angle);
            REG_BARREL:  prdata = APB_DATA_W'(cfg_reg.barrel_angle);
            REG_HYST:    prdata = APB_DATA_W'(cfg_reg.hysteresis);
            REG_TIMEOUT: prdata = APB_DATA_W'(cfg_reg.timeout_ticks);
            default:     prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.closed_angle  <= CLOSED_RST;
            cfg_reg.tank_angle    <= TANK_RST;
            cfg_reg.barrel_angle  <= BARREL_RST;
            cfg_reg.hysteresis    <= HYST_RST;
            cfg_reg.timeout_ticks <= TIMEOUT_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

/* rtl/vpt_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpt_core
// Move state, tick timer, ranking and classification for one request.
// ----------------------------------------------------------------------------
module vpt_core
    import vpt_pkg::*;
#(
    parameter int TIMER_WIDTH = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               step,
    input  cfg_t               cfg,
    input  logic [1:0]         opcode,
    input  logic [1:0]         target_position,
    input  logic [ANGLE_W-1:0] angle_sample,
    output res_t               res
);

    localparam int CMP_W = (TIMER_WIDTH > TIMEOUT_W) ? TIMER_WIDTH : TIMEOUT_W;
    localparam logic [TIMER_WIDTH-1:0] TICK_MAX = '1;

    logic                   moving_reg, moving_next;
    pos_t                   move_target_reg, move_target_next;
    logic [ANGLE_W-1:0]     start_angle_reg, start_angle_next;
    logic [TIMER_WIDTH-1:0] tick_count_reg, tick_count_next;
    pos_t                   cur_pos_reg, cur_pos_next;
    rank_t                  rank_reg, rank_next;

    pos_t                   tgt;
    logic [ANGLE_W-1:0]     dest;
    logic [TIMER_WIDTH-1:0] tick_inc;
    logic                   timed_out;
    drive_t                 drive;
    logic                   fin;
    logic                   ok;

    assign tgt      = (target_position == 2'd3) ? POS_CLOSED : pos_t'(target_position);
    assign dest     = pos_angle(cfg, moving_reg ? move_target_reg : tgt);
    assign tick_inc = (tick_count_reg == TICK_MAX) ? tick_count_reg
                                                   : tick_count_reg + TIMER_WIDTH'(1);
    assign timed_out = (CMP_W'(tick_inc) >= CMP_W'(cfg.timeout_ticks))
                       || (tick_inc == TICK_MAX);

    always_comb begin
        moving_next      = moving_reg;
        move_target_next = move_target_reg;
        start_angle_next = start_angle_reg;
        tick_count_next  = tick_count_reg;
        cur_pos_next     = cur_pos_reg;
        rank_next        = rank_reg;
        drive            = DRV_BRAKE;
        fin              = 1'b0;
        ok               = 1'b0;
        priority if (moving_reg) begin
            tick_count_next = tick_inc;
            priority if (reached(dest, angle_sample, start_angle_reg, cfg.hysteresis)) begin
                moving_next  = 1'b0;
                fin          = 1'b1;
                ok           = 1'b1;
                cur_pos_next = move_target_reg;
            end else if (timed_out) begin
                moving_next = 1'b0;
                fin         = 1'b1;
            end else begin
                drive = (dest > start_angle_reg) ? DRV_FORWARD : DRV_BACKWARD;
            end
        end else if (opcode == OP_MOVE) begin
            priority if (cur_pos_reg == tgt) begin
                fin = 1'b1;
                ok  = 1'b1;
            end else if (reached(dest, angle_sample, angle_sample, cfg.hysteresis)) begin
                fin          = 1'b1;
                ok           = 1'b1;
                cur_pos_next = tgt;
            end else begin
                moving_next      = 1'b1;
                move_target_next = tgt;
                start_angle_next = angle_sample;
                tick_count_next  = '0;
                drive = (dest > angle_sample) ? DRV_FORWARD : DRV_BACKWARD;
            end
        end else if (opcode == OP_REFRESH) begin
            rank_next    = rank_angles(cfg);
            cur_pos_next = classify(cfg, rank_next, angle_sample);
        end else begin
            drive = DRV_BRAKE;
        end
    end

    assign res.motor_drive     = drive;
    assign res.busy_res        = moving_next;
    assign res.finished        = fin;
    assign res.succeeded       = ok;
    assign res.position_class  = classify(cfg, rank_next, angle_sample);
    assign res.stored_position = cur_pos_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            moving_reg      <= 1'b0;
            move_target_reg <= POS_CLOSED;
            start_angle_reg <= '0;
            tick_count_reg  <= '0;
            cur_pos_reg     <= POS_CLOSED;
            rank_reg.low    <= POS_CLOSED;
            rank_reg.mid    <= POS_TANK;
            rank_reg.high   <= POS_BARREL;
        end else if (step) begin
            moving_reg      <= moving_next;
            move_target_reg <= move_target_next;
            start_angle_reg <= start_angle_next;
            tick_count_reg  <= tick_count_next;
            cur_pos_reg     <= cur_pos_next;
            rank_reg        <= rank_next;
        end
    end

    a_end_reports: assert property (@(posedge aclk) disable iff (!aresetn)
        (step && moving_reg && !moving_next) |-> res.finished)
        else $error("move ended without finish");

    a_drive_only_moving: assert property (@(posedge aclk) disable iff (!aresetn)
        (step && res.motor_drive != DRV_BRAKE) |-> moving_next)
        else $error("motor driven while not moving");

    a_finish_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (step && res.finished) |-> !moving_next)
        else $error("finished while still moving");

    a_tick_counts: assert property (@(posedge aclk) disable iff (!aresetn)
        (step && moving_reg) |=> tick_count_reg != '0)
        else $error("tick counter did not advance");

endmodule

/* rtl/valve_positioner_with_timeout.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// valve_positioner_with_timeout
// Bang-bang valve positioner with move timeout, position ranking and resync.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake              | payload
//  s_       | in        | s_tvalid / s_tready    | tuser opcode, tdata target + angle
//  m_       | out       | m_tvalid / m_tready    | tdata drive, flags, class, position
//  apb      | in        | psel / penable, pready | closed, tank, barrel, hyst, timeout
//
// one request per cycle sustained while m_tready is high; each request is taken
// into an input register, worked on combinationally and held in the result
// register; m_tvalid rises once the request has passed both registers
// aresetn is synchronous, active low; resets move state, ranking and registers
// a stalled m_ side holds the result; the input register still takes one
// request, then s_tready follows m_tready
// ----------------------------------------------------------------------------
module valve_positioner_with_timeout
    import vpt_pkg::*;
#(
    parameter int TIMER_WIDTH = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [15:0]           s_tdata,   // target_position, angle_sample
    input  logic [1:0]            s_tuser,   // opcode
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [15:0]           m_tdata,   // motor_drive, busy_res, finished,
                                             // succeeded, position_class,
                                             // stored_position
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    cfg_t               cfg;
    res_t               res;
    logic               in_valid_reg;
    logic [1:0]         in_op_reg;
    logic [1:0]         in_tgt_reg;
    logic [ANGLE_W-1:0] in_angle_reg;
    logic               out_valid_reg;
    res_t               out_res_reg;
    logic               advance;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    vpt_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    vpt_core #(
        .TIMER_WIDTH (TIMER_WIDTH)
    ) u_core (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .step            (advance),
        .cfg             (cfg),
        .opcode          (in_op_reg),
        .target_position (in_tgt_reg),
        .angle_sample    (in_angle_reg),
        .res             (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_op_reg    <= s_tuser;
            in_tgt_reg   <= s_tdata[1:0];
            in_angle_reg <= s_tdata[ANGLE_W+1:2];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_res_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0,
                       out_res_reg.stored_position,
                       out_res_reg.position_class,
                       out_res_reg.succeeded,
                       out_res_reg.finished,
                       out_res_reg.busy_res,
                       out_res_reg.motor_drive};

endmodule

/* sim/vpt_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpt_checker
// Watches the request, result and register ports of the valve positioner,
// keeps its own copy of the move state and the ranking, predicts the
// response of every accepted request and compares each returned result
// field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module vpt_checker
    import vpt_pkg::*;
#(
    parameter int TIMER_WIDTH = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [15:0]           s_tdata,   // target_position, angle_sample
    input  logic [1:0]            s_tuser,   // opcode
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [15:0]           m_tdata,   // motor_drive, busy_res, finished,
                                             // succeeded, position_class,
                                             // stored_position
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic                  pready,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output int                    mismatches,
    output int                    outstanding
);

    logic [ANGLE_W-1:0]     cfg_closed;
    logic [ANGLE_W-1:0]     cfg_tank;
    logic [ANGLE_W-1:0]     cfg_barrel;
    logic [HYST_W-1:0]      cfg_hyst;
    logic [TIMEOUT_W-1:0]   cfg_timeout;

    logic                   valve_moving;
    pos_t                   move_dest;
    logic [ANGLE_W-1:0]     start_ang;
    logic [TIMER_WIDTH-1:0] ticks;
    pos_t                   stored_pos;
    pos_t                   rk_low;
    pos_t                   rk_mid;
    pos_t                   rk_high;

    res_t                   expected_responses[$];

    function automatic int angle_for(pos_t p);
        int a;
        if (p == POS_TANK) begin
            a = int'(cfg_tank);
        end else if (p == POS_BARREL) begin
            a = int'(cfg_barrel);
        end else begin
            a = int'(cfg_closed);
        end
        return a;
    endfunction

    function automatic logic target_hit(int dest, int cur, int st);
        logic hit;
        if (st < dest) begin
            hit = cur >= dest - int'(cfg_hyst);
        end else if (st > dest) begin
            hit = cur <= dest + int'(cfg_hyst);
        end else begin
            hit = 1'b1;
        end
        return hit;
    endfunction

    function automatic pos_t classify_angle(int cur);
        pos_t p;
        if (cur <= angle_for(rk_low) + int'(cfg_hyst)) begin
            p = rk_low;
        end else if (cur >= angle_for(rk_high) - int'(cfg_hyst)) begin
            p = rk_high;
        end else begin
            p = rk_mid;
        end
        return p;
    endfunction

    // ties: closed then tank override barrel on <= for low and >= for high
    function automatic void rerank();
        pos_t lo;
        pos_t hi;
        int   a;
        int   b;
        lo = POS_BARREL;
        hi = POS_BARREL;
        a  = int'(cfg_barrel);
        b  = int'(cfg_barrel);
        if (int'(cfg_closed) <= a) begin
            a  = int'(cfg_closed);
            lo = POS_CLOSED;
        end
        if (int'(cfg_closed) >= b) begin
            b  = int'(cfg_closed);
            hi = POS_CLOSED;
        end
        if (int'(cfg_tank) <= a) begin
            lo = POS_TANK;
        end
        if (int'(cfg_tank) >= b) begin
            hi = POS_TANK;
        end
        rk_low  = lo;
        rk_high = hi;
        if (hi != POS_BARREL && lo != POS_BARREL) begin
            rk_mid = POS_BARREL;
        end else if (hi != POS_CLOSED && lo != POS_CLOSED) begin
            rk_mid = POS_CLOSED;
        end else begin
            rk_mid = POS_TANK;
        end
    endfunction

    function automatic void restore_defaults();
        cfg_closed   = CLOSED_RST;
        cfg_tank     = TANK_RST;
        cfg_barrel   = BARREL_RST;
        cfg_hyst     = HYST_RST;
        cfg_timeout  = TIMEOUT_RST;
        valve_moving = 1'b0;
        move_dest    = POS_CLOSED;
        start_ang    = '0;
        ticks        = '0;
        stored_pos   = POS_CLOSED;
        rk_low       = POS_CLOSED;
        rk_mid       = POS_TANK;
        rk_high      = POS_BARREL;
    endfunction

    function automatic res_t predict_valve_response(logic [1:0] op, logic [1:0] tgt_raw,
                                                    logic [ANGLE_W-1:0] ang);
        pos_t tgt;
        int   cur;
        int   dest;
        int   st;
        res_t r;
        cur           = int'(ang);
        tgt           = (tgt_raw > POS_BARREL) ? POS_CLOSED : pos_t'(tgt_raw);
        r.motor_drive = DRV_BRAKE;
        r.finished    = 1'b0;
        r.succeeded   = 1'b0;
        if (valve_moving) begin
            // commands and refreshes are plain ticks while a move runs
            dest = angle_for(move_dest);
            st   = int'(start_ang);
            if (ticks != '1) begin
                ticks = ticks + TIMER_WIDTH'(1);
            end
            if (target_hit(dest, cur, st)) begin
                valve_moving = 1'b0;
                r.finished   = 1'b1;
                r.succeeded  = 1'b1;
                stored_pos   = move_dest;
            end else if (ticks >= cfg_timeout || ticks == '1) begin
                valve_moving = 1'b0;
                r.finished   = 1'b1;
            end else begin
                r.motor_drive = (dest > st) ? DRV_FORWARD : DRV_BACKWARD;
            end
        end else if (op == OP_MOVE) begin
            dest = angle_for(tgt);
            if (stored_pos == tgt) begin
                r.finished  = 1'b1;
                r.succeeded = 1'b1;
            end else if (target_hit(dest, cur, cur)) begin
                r.finished  = 1'b1;
                r.succeeded = 1'b1;
                stored_pos  = tgt;
            end else begin
                valve_moving  = 1'b1;
                move_dest     = tgt;
                start_ang     = ang;
                ticks         = '0;
                r.motor_drive = (dest > cur) ? DRV_FORWARD : DRV_BACKWARD;
            end
        end else if (op == OP_REFRESH) begin
            rerank();
            stored_pos = classify_angle(cur);
        end
        r.busy_res        = valve_moving;
        r.position_class  = classify_angle(cur);
        r.stored_position = stored_pos;
        return r;
    endfunction

    always @(posedge aclk) begin : watch
        res_t got;
        res_t want;
        if (!aresetn) begin
            restore_defaults();
            expected_responses.delete();
            mismatches = 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (reg_idx_t'(paddr[APB_ADDR_W-1:2]))
                    REG_CLOSED:  cfg_closed  = pwdata[ANGLE_W-1:0];
                    REG_TANK:    cfg_tank    = pwdata[ANGLE_W-1:0];
                    REG_BARREL:  cfg_barrel  = pwdata[ANGLE_W-1:0];
                    REG_HYST:    cfg_hyst    = pwdata[HYST_W-1:0];
                    REG_TIMEOUT: cfg_timeout = pwdata[TIMEOUT_W-1:0];
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                got.motor_drive     = drive_t'(m_tdata[1:0]);
                got.busy_res        = m_tdata[2];
                got.finished        = m_tdata[3];
                got.succeeded       = m_tdata[4];
                got.position_class  = pos_t'(m_tdata[6:5]);
                got.stored_position = pos_t'(m_tdata[8:7]);
                if (expected_responses.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("%0t ns: result with no request pending, data %h",
                                 $time, m_tdata);
                    end
                end else begin
                    want = expected_responses.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display({"%0t ns: mismatch drive/busy/fin/ok/class/pos",
                                      " expected %0d/%0b/%0b/%0b/%0d/%0d",
                                      " got %0d/%0b/%0b/%0b/%0d/%0d"}, $time,
                                     want.motor_drive, want.busy_res, want.finished,
                                     want.succeeded, want.position_class,
                                     want.stored_position,
                                     got.motor_drive, got.busy_res, got.finished,
                                     got.succeeded, got.position_class,
                                     got.stored_position);
                        end
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                expected_responses.push_back(
                    predict_valve_response(s_tuser, s_tdata[1:0], s_tdata[10:2]));
            end
        end
        outstanding = expected_responses.size();
    end

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the valve positioner: directed moves, timeouts, ignored
// commands and ranking ties, then phases of fixed and random register settings
// with move sequences that walk the angle toward the target. Both channels idle
// at random; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_top;
    import vpt_pkg::*;

    localparam logic [1:0] OP_UNUSED  = 2'd3;
    localparam logic [1:0] POS_UNUSED = 2'd3;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [15:0]           s_tdata;   // target_position, angle_sample
    logic [1:0]            s_tuser;   // opcode
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [15:0]           m_tdata;   // motor_drive, busy_res, finished,
                                      // succeeded, position_class,
                                      // stored_position
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    int                    mismatch_total;
    int                    pending_count;

    int                    items_sent;
    int                    burst_left;
    int                    hold_reqs;
    int                    ang_closed;
    int                    ang_tank;
    int                    ang_barrel;

    valve_positioner_with_timeout #(
        .TIMER_WIDTH(16)
    ) DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    vpt_checker #(
        .TIMER_WIDTH(16)
    ) u_vpt_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .pready     (pready),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .mismatches (mismatch_total),
        .outstanding(pending_count)
    );

    initial begin
        aclk = 1'b0;
        forever begin
            #4 aclk = ~aclk;
        end
    end

    initial begin
        #4_000_000;
        $display("simulation failed");
        $finish;
    end

    // result side stall patterns, plus a long hold on request
    initial begin : receiver
        int rx_mode;
        int mode_left;
        int hold_left;
        int hold_seen;
        int cyc;
        rx_mode   = 0;
        mode_left = 0;
        hold_left = 0;
        hold_seen = 0;
        cyc       = 0;
        forever begin
            @(negedge aclk);
            cyc++;
            if (hold_reqs != hold_seen) begin
                hold_seen = hold_reqs;
                hold_left = 150;
            end
            if (mode_left == 0) begin
                rx_mode   = $urandom_range(0, 3);
                mode_left = $urandom_range(20, 300);
            end
            mode_left--;
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                case (rx_mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= ($urandom_range(0, 3) != 0);
                    2:       m_tready <= ($urandom_range(0, 3) == 0);
                    default: m_tready <= ((cyc % 5) < 3);
                endcase
            end
        end
    end

    task automatic send_item(input logic [1:0] op, input logic [1:0] tgt, input int ang);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            burst_left = $urandom_range(1, 24);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {5'd0, 9'(ang), tgt};
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
        @(negedge aclk);
        burst_left--;
        items_sent++;
    endtask

    task automatic wait_drained();
        s_tvalid   <= 1'b0;
        burst_left = 0;
        do begin
            @(negedge aclk);
        end while (pending_count != 0);
    endtask

    task automatic apb_write(input reg_idx_t idx, input int val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic configure(input int c, input int t, input int b, input int h,
                             input int to);
        apb_write(REG_CLOSED, c);
        apb_write(REG_TANK, t);
        apb_write(REG_BARREL, b);
        apb_write(REG_HYST, h);
        apb_write(REG_TIMEOUT, to);
        ang_closed = c;
        ang_tank   = t;
        ang_barrel = b;
    endtask

    function automatic int angle_of(logic [1:0] p);
        int a;
        if (p == POS_TANK) begin
            a = ang_tank;
        end else if (p == POS_BARREL) begin
            a = ang_barrel;
        end else begin
            a = ang_closed;
        end
        return a;
    endfunction

    // move command followed by ticks that mostly walk toward the target
    task automatic run_move_sequence();
        logic [1:0] tgt;
        logic [1:0] op;
        int         dest;
        int         ang;
        int         step;
        int         n;
        tgt  = 2'($urandom_range(0, 3));
        dest = angle_of(tgt);
        ang  = $urandom_range(0, 360);
        send_item(OP_MOVE, tgt, ang);
        n = $urandom_range(1, 12);
        repeat (n) begin
            step = $urandom_range(1, 25);
            if ($urandom_range(0, 7) == 0) begin
                ang = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 511)
                                                  : $urandom_range(0, 360);
            end else if (ang < dest) begin
                ang = (ang + step > 360) ? 360 : ang + step;
            end else if (ang > dest) begin
                ang = (ang - step < 0) ? 0 : ang - step;
            end
            op = ($urandom_range(0, 7) == 0) ? 2'($urandom_range(0, 3)) : OP_TICK;
            send_item(op, 2'($urandom_range(0, 3)), ang);
        end
    endtask

    initial begin : stimulus
        int phase_goal;
        int c;
        int t;
        int b;
        aresetn    = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = '0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        items_sent = 0;
        burst_left = 0;
        hold_reqs  = 0;
        ang_closed = int'(CLOSED_RST);
        ang_tank   = int'(TANK_RST);
        ang_barrel = int'(BARREL_RST);
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset settings: at-once success, ignored command and refresh, reach
        send_item(OP_TICK, POS_CLOSED, 0);
        send_item(OP_MOVE, POS_CLOSED, 0);
        send_item(OP_MOVE, POS_TANK, 0);
        send_item(OP_MOVE, POS_BARREL, 40);
        send_item(OP_REFRESH, POS_CLOSED, 60);
        send_item(OP_TICK, POS_CLOSED, 85);
        send_item(OP_MOVE, POS_BARREL, 176);
        send_item(OP_MOVE, POS_UNUSED, 360);
        send_item(OP_UNUSED, POS_UNUSED, 511);
        send_item(OP_TICK, POS_BARREL, 5);
        send_item(OP_REFRESH, POS_TANK, 100);
        send_item(OP_REFRESH, POS_CLOSED, 255);
        wait_drained();

        // all angles equal, no tolerance, zero timeout
        configure(100, 100, 100, 0, 0);
        send_item(OP_REFRESH, POS_CLOSED, 100);
        send_item(OP_REFRESH, POS_CLOSED, 0);
        send_item(OP_MOVE, POS_BARREL, 0);
        send_item(OP_TICK, POS_CLOSED, 50);
        send_item(OP_MOVE, POS_CLOSED, 100);
        wait_drained();

        // widest tolerance, short timeout
        configure(360, 0, 180, 63, 3);
        send_item(OP_REFRESH, POS_CLOSED, 300);
        send_item(OP_MOVE, POS_TANK, 360);
        send_item(OP_TICK, POS_CLOSED, 200);
        send_item(OP_TICK, POS_CLOSED, 200);
        send_item(OP_TICK, POS_CLOSED, 200);
        send_item(OP_MOVE, POS_TANK, 64);
        send_item(OP_TICK, POS_CLOSED, 63);
        wait_drained();

        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                0: configure(0, 90, 180, 5, 20);
                1: configure(0, 360, 180, 63, 65535);
                2: configure(360, 0, 0, 0, 1);
                default: begin
                    c = $urandom_range(0, 360);
                    t = $urandom_range(0, 360);
                    b = ($urandom_range(0, 3) == 0) ? c : $urandom_range(0, 360);
                    configure(c, t, b,
                              ($urandom_range(0, 1) == 0) ? $urandom_range(0, 15)
                                                          : $urandom_range(0, 63),
                              ($urandom_range(0, 5) == 0) ? 65535 : $urandom_range(0, 30));
                end
            endcase
            if (phase == 2) begin
                hold_reqs++;
            end
            phase_goal = items_sent + 235;
            while (items_sent < phase_goal) begin
                case ($urandom_range(0, 9))
                    0: send_item(OP_REFRESH, 2'($urandom_range(0, 3)), $urandom_range(0, 360));
                    1: send_item(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                                 $urandom_range(0, 511));
                    default: run_move_sequence();
                endcase
            end
            wait_drained();
        end

        repeat (10) @(negedge aclk);
        if (mismatch_total == 0 && pending_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/vpt_pkg.sv
rtl/vpt_cfg_regs.sv
rtl/vpt_core.sv
rtl/valve_positioner_with_timeout.sv
sim/vpt_checker.sv
sim/tb_top.sv
